// ===== hw/rtl/rtfml_pkg.sv =====
// ============================================================================
// Route table first-match lookup: shared package
// Types, widths, command codes and the mask popcount used by the lookup unit.
// ============================================================================
`default_nettype none

package rtfml_pkg;

	// Number of route slots in the table.
	localparam int TABLE_DEPTH = 128;

	// Slot index width and the width of an entry count (0 .. TABLE_DEPTH).
	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	// Width of a 32-bit popcount (0 .. 32).
	localparam int POP_W = 6;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [POP_W-1:0] pop_t;
	typedef logic [6:0]       out_idx_t;

	typedef enum logic [1:0] {
		CMD_WRITE   = 2'd0,
		CMD_EXACT   = 2'd1,
		CMD_SUBSUME = 2'd2,
		CMD_COUNT   = 2'd3
	} cmd_e;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN
	} state_e;

	// One request as it arrives on the command port.
	typedef struct packed {
		cmd_e        command;
		logic [7:0]  slot;
		logic [31:0] address;
		logic [31:0] mask;
	} req_t;

	// One result.
	typedef struct packed {
		logic     found;
		out_idx_t match_index;
	} rsp_t;

	// One stored route. The mask popcount is computed once at write time.
	typedef struct packed {
		pop_t        pop;
		logic [31:0] dest;
		logic [31:0] mask;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// Lookup key held for the length of a scan.
	typedef struct packed {
		logic        subsume;
		logic [31:0] address;
		logic [31:0] mask;
		pop_t        pop;
	} query_t;

	// Popcount of a 32-bit word as a five-level adder tree.
	function automatic pop_t popcount32(input logic [31:0] v);
		logic [1:0] l1 [16];
		logic [2:0] l2 [8];
		logic [3:0] l3 [4];
		logic [4:0] l4 [2];
		for (int i = 0; i < 16; i++) begin
			l1[i] = 2'(v[2*i]) + 2'(v[2*i+1]);
		end
		for (int i = 0; i < 8; i++) begin
			l2[i] = 3'(l1[2*i]) + 3'(l1[2*i+1]);
		end
		for (int i = 0; i < 4; i++) begin
			l3[i] = 4'(l2[2*i]) + 4'(l2[2*i+1]);
		end
		for (int i = 0; i < 2; i++) begin
			l4[i] = 5'(l3[2*i]) + 5'(l3[2*i+1]);
		end
		return pop_t'(l4[0]) + pop_t'(l4[1]);
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/rtfml_ram.sv =====
// ============================================================================
// Generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data is registered.
// ============================================================================
`default_nettype none

module rtfml_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                    clk,
	input  wire logic                                    we,
	input  wire logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                        wdata,
	input  wire logic                                    re,
	input  wire logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0] raddr,
	output logic      [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/rtfml_match.sv =====
// ============================================================================
// Route entry comparator
// Decides whether one stored route matches the current lookup key.
// ============================================================================
`default_nettype none

module rtfml_match (
	input  wire rtfml_pkg::entry_t entry,
	input  wire rtfml_pkg::query_t query,
	output logic                   hit
);

	logic exact_hit;
	logic subsume_hit;

	always_comb begin
		exact_hit   = (entry.dest == query.address) && (entry.mask == query.mask);
		// The entry mask must be no more specific than the query mask, and the
		// addresses must agree on every bit the entry mask covers.
		subsume_hit = (entry.pop <= query.pop)
			&& (((entry.dest ^ query.address) & entry.mask) == 32'h0);
		hit         = query.subsume ? subsume_hit : exact_hit;
	end

endmodule

`default_nettype wire

// ===== hw/rtl/rtfml_scan.sv =====
// ============================================================================
// Command sequencer and table scanner
// Takes commands, writes routes, keeps the entry count and walks the table.
// ============================================================================
`default_nettype none

module rtfml_scan (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	output logic                     busy,
	input  wire rtfml_pkg::req_t     request,
	output logic                     done,
	output rtfml_pkg::rsp_t          result,
	output logic                     ram_we,
	output rtfml_pkg::idx_t          ram_waddr,
	output rtfml_pkg::entry_t        ram_wdata,
	output logic                     ram_re,
	output rtfml_pkg::idx_t          ram_raddr,
	output rtfml_pkg::query_t        query,
	input  wire logic                hit
);

	rtfml_pkg::state_e state_q, state_d;
	rtfml_pkg::idx_t   rd_idx_q, rd_idx_d;
	rtfml_pkg::cnt_t   entries_q, entries_d;
	rtfml_pkg::query_t query_q, query_d;
	rtfml_pkg::cnt_t   rd_next;
	rtfml_pkg::pop_t   req_pop;
	rtfml_pkg::rsp_t   rsp_q, rsp_d;
	logic              done_q, done_d;
	logic              accept;
	logic              last_issue;
	logic              valid_s1, valid_s1_d;
	logic              last_s1;
	rtfml_pkg::idx_t   idx_s1;

	assign busy      = (state_q != rtfml_pkg::ST_IDLE);
	assign accept    = start && !busy;
	assign req_pop   = rtfml_pkg::popcount32(request.mask);
	assign rd_next   = rtfml_pkg::cnt_t'(rd_idx_q) + rtfml_pkg::cnt_t'(1);
	assign last_issue = (rd_next == entries_q);

	assign ram_we    = accept && (request.command == rtfml_pkg::CMD_WRITE)
		&& (32'(request.slot) < 32'(rtfml_pkg::TABLE_DEPTH));
	assign ram_waddr = rtfml_pkg::idx_t'(request.slot);
	assign ram_wdata = '{pop: req_pop, dest: request.address, mask: request.mask};
	assign ram_re    = (state_q == rtfml_pkg::ST_SCAN);
	assign ram_raddr = rd_idx_q;
	assign query     = query_q;
	assign done      = done_q;
	assign result    = rsp_q;

	always_comb begin
		state_d    = state_q;
		rd_idx_d   = rd_idx_q;
		entries_d  = entries_q;
		query_d    = query_q;
		done_d     = 1'b0;
		rsp_d      = '0;
		valid_s1_d = 1'b0;
		unique case (state_q)
			rtfml_pkg::ST_IDLE: begin
				if (accept) begin
					unique case (request.command)
						rtfml_pkg::CMD_WRITE: begin
							done_d = 1'b1;
						end
						rtfml_pkg::CMD_COUNT: begin
							done_d = 1'b1;
							if (32'(request.slot) > 32'(rtfml_pkg::TABLE_DEPTH)) begin
								entries_d = rtfml_pkg::cnt_t'(rtfml_pkg::TABLE_DEPTH);
							end else begin
								entries_d = rtfml_pkg::cnt_t'(request.slot);
							end
						end
						rtfml_pkg::CMD_EXACT, rtfml_pkg::CMD_SUBSUME: begin
							query_d = '{subsume: (request.command == rtfml_pkg::CMD_SUBSUME),
								address: request.address, mask: request.mask, pop: req_pop};
							if (entries_q == '0) begin
								done_d = 1'b1;
							end else begin
								state_d  = rtfml_pkg::ST_SCAN;
								rd_idx_d = '0;
							end
						end
						default: begin
							done_d = 1'b1;
						end
					endcase
				end
			end
			rtfml_pkg::ST_SCAN, rtfml_pkg::ST_DRAIN: begin
				if (valid_s1 && hit) begin
					done_d            = 1'b1;
					rsp_d.found       = 1'b1;
					rsp_d.match_index = rtfml_pkg::out_idx_t'(idx_s1);
					state_d           = rtfml_pkg::ST_IDLE;
				end else if (valid_s1 && last_s1) begin
					done_d  = 1'b1;
					state_d = rtfml_pkg::ST_IDLE;
				end else if (state_q == rtfml_pkg::ST_SCAN) begin
					valid_s1_d = 1'b1;
					rd_idx_d   = rtfml_pkg::idx_t'(rd_next);
					if (last_issue) begin
						state_d = rtfml_pkg::ST_DRAIN;
					end
				end
			end
			default: begin
				state_d = rtfml_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= rtfml_pkg::ST_IDLE;
			entries_q <= '0;
			done_q    <= 1'b0;
			rsp_q     <= '0;
			valid_s1  <= 1'b0;
		end else begin
			state_q   <= state_d;
			entries_q <= entries_d;
			done_q    <= done_d;
			rsp_q     <= rsp_d;
			valid_s1  <= valid_s1_d;
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_q <= rd_idx_d;
		query_q  <= query_d;
		idx_s1   <= rd_idx_q;
		last_s1  <= last_issue;
	end

	a_s1_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (state_q != rtfml_pkg::ST_IDLE))
		else $error("compare stage valid outside a scan");

	a_drain_has_data: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rtfml_pkg::ST_DRAIN) |-> valid_s1)
		else $error("drain state without a pending compare");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (state_q == rtfml_pkg::ST_IDLE))
		else $error("result strobe while still scanning");

	a_found_with_done: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_q.found |-> done_q)
		else $error("found flag without result strobe");

	a_scan_needs_entries: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rtfml_pkg::ST_SCAN) |-> (entries_q != '0))
		else $error("scan running on an empty table");

endmodule

`default_nettype wire

// ===== hw/rtl/route_table_first_match_lookup_unit.sv =====
// ============================================================================
// Route table first-match lookup unit
// IPv4 route table with write, count and first-match lookup commands.
// ============================================================================
//
//  Channel   Handshake            Payload              Direction
//  --------  -------------------  -------------------  ---------
//  command   start / busy         request (req_t)      in
//  result    done (strobe)        result  (rsp_t)      out
//
// A request is taken at a rising edge with start high and busy low. Write
// and set-count requests strobe their result in the next cycle and busy
// never rises, so they may follow each other every cycle. A lookup over
// N entries in use holds busy while up to N slots are read, one per cycle,
// and each read word passes the route memory's output register and the
// compare stage. The scan stops at the first hit. An empty table answers
// a lookup without a scan, with its result strobe in the next cycle.
// Reset clears the entry count and the sequencer; the route memory itself
// is not cleared, and a route is only meaningful after it has been written.
// The result strobe lasts exactly one cycle and the receiver cannot stall it.
// ============================================================================
`default_nettype none

module route_table_first_match_lookup_unit (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	output logic                 busy,
	input  wire rtfml_pkg::req_t request,
	output logic                 done,
	output rtfml_pkg::rsp_t      result
);

	// Write port of the route memory, enabled when a write request for a slot inside the table is taken.
	logic                 ram_we;
	rtfml_pkg::idx_t      ram_waddr;
	rtfml_pkg::entry_t    ram_wdata;

	// Read port, stepped through the table one slot per cycle during a scan.
	logic                 ram_re;
	rtfml_pkg::idx_t      ram_raddr;
	logic [rtfml_pkg::ENTRY_W-1:0] ram_rdata;
	rtfml_pkg::entry_t    entry;

	// The lookup key latched when the lookup request was taken.
	rtfml_pkg::query_t    query;
	logic                 hit;

	assign entry = rtfml_pkg::entry_t'(ram_rdata);

	// The sequencer owns the command handshake, the entry count, the scan
	// counter and the one-entry compare stage that lines up with the memory.
	rtfml_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.request   (request),
		.done      (done),
		.result    (result),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.query     (query),
		.hit       (hit)
	);

	// Each word holds destination, mask and the mask's popcount, so the
	// subsuming compare needs no adder tree on the read path.
	rtfml_ram #(
		.WIDTH (rtfml_pkg::ENTRY_W),
		.DEPTH (rtfml_pkg::TABLE_DEPTH)
	) u_routes (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Compares the entry just read against the lookup key.
	rtfml_match u_match (
		.entry (entry),
		.query (query),
		.hit   (hit)
	);

endmodule

`default_nettype wire
